[sv/sht_pkg.sv]
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the sorted handle table: entry layout,
// operation and status codes, and the request token that walks the cell row.
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int HANDLE_W      = 32;
  localparam int ID_W          = 16;
  localparam int ENTRY_W       = HANDLE_W + ID_W;   // handle in upper bits, id in lower
  localparam int COUNT_OUT_W   = 7;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  // Request token handed from cell to cell, one cell per cycle.
  // flag: insert -> entry already placed (carry is being pushed down);
  //       remove -> id matched, cells pull from their successor;
  //       lookup -> handle matched, carry holds the matching entry.
  typedef struct packed {
    logic                active;
    op_t                 op;
    logic                flag;
    logic [ENTRY_W-1:0]  carry;
    logic [HANDLE_W-1:0] key_handle;
    logic [ID_W-1:0]     key_id;
  } token_t;

endpackage

[sv/sht_cell.sv]
// ----------------------------------------------------------------------------
// sht_cell
// One position of a sorted table. Holds one entry and acts on the request
// token as it passes, then hands the token to the next position.
// ----------------------------------------------------------------------------
module sht_cell import sht_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CW-1:0]      count,
  input  token_t             tok_in,
  input  logic [ENTRY_W-1:0] next_entry,
  output token_t             tok_out,
  output logic [ENTRY_W-1:0] entry
);

  localparam logic [CW-1:0] POS = CW'(IDX);

  token_t              tok_next;
  logic [ENTRY_W-1:0]  entry_next;
  logic [HANDLE_W-1:0] my_handle;
  logic [ID_W-1:0]     my_id;
  logic                in_range;
  logic                at_end;

  assign my_handle = entry[ENTRY_W-1:ID_W];
  assign my_id     = entry[ID_W-1:0];
  assign in_range  = (POS < count);
  assign at_end    = (POS == count);

  always_comb begin
    tok_next   = tok_in;
    entry_next = entry;
    if (tok_in.active) begin
      unique case (tok_in.op)
        OP_INSERT: begin
          if (in_range) begin
            // first entry with handle >= key takes the new one, rest shift down
            if (tok_in.flag || my_handle >= tok_in.key_handle) begin
              entry_next     = tok_in.carry;
              tok_next.carry = entry;
              tok_next.flag  = 1'b1;
            end
          end else if (at_end) begin
            entry_next = tok_in.carry;
          end
        end
        OP_REMOVE: begin
          if (in_range && (tok_in.flag || my_id == tok_in.key_id)) begin
            entry_next    = next_entry;
            tok_next.flag = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (in_range && !tok_in.flag && my_handle == tok_in.key_handle) begin
            tok_next.flag  = 1'b1;
            tok_next.carry = entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    entry <= entry_next;
  end

endmodule

[sv/sht_chain.sv]
// ----------------------------------------------------------------------------
// sht_chain
// Row of DEPTH cells forming one sorted table. The token enters at position
// zero, is registered in every cell and leaves at the tail.
// ----------------------------------------------------------------------------
module sht_chain import sht_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] count,
  input  token_t        head,
  output token_t        tail
);

  token_t             toks    [DEPTH+1];
  logic [ENTRY_W-1:0] entries [DEPTH];

  assign toks[0] = head;
  assign tail    = toks[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end

    sht_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count      (count),
      .tok_in     (toks[i]),
      .next_entry (nxt),
      .tok_out    (toks[i+1]),
      .entry      (entries[i])
    );
  end

endmodule

[sv/sorted_handle_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_handle_table_unit
// Two sorted (handle, id) tables, each a row of cells. Insert keeps handle
// order, remove deletes the first entry with an id, lookup finds by handle.
//
//   port group | dir | tdata (low bit up)                | tuser (low bit up)
//   s_axis     | in  | handle[31:0], entry_id[47:32]     | operation[1:0], table_select[2]
//   m_axis     | out | found_id[15:0], entry_count[22:16]| status[1:0]
//
// One request at a time: a request walks the selected table's cell row one
// position per cycle, its result is registered when the token leaves the tail,
// and the next request can be accepted once that result is registered.
// The output register plus one spare result slot let a request be accepted
// while a result waits; s_axis_tready is low while a request walks the row
// and while the spare slot is full.
// rst is synchronous; both table counts clear to zero, entries are not reset.
// ----------------------------------------------------------------------------
module sorted_handle_table_unit import sht_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // handle[31:0], entry_id[47:32]
  input  logic [2:0]  s_axis_tuser,   // operation[1:0], table_select[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // found_id[15:0], entry_count[22:16], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        id;
    logic [COUNT_OUT_W-1:0] count;
  } result_t;

  state_t          state;
  logic [CW-1:0]   counts [2];
  token_t          head_tok;
  logic [1:0]      launch;
  token_t          tails [2];
  op_t             op_r;
  logic            tsel_r;
  logic            full_r;

  result_t         out_res;
  result_t         pend_res;
  logic            pend_valid;

  logic            accept;
  logic            take;
  logic            done;
  op_t             in_op;
  logic            in_tsel;
  logic [CW-1:0]   in_cnt;
  logic            in_full;
  logic [CW-1:0]   cur_cnt;
  logic [CW-1:0]   cnt_next;
  result_t         res;
  token_t          tail_sel;

  assign in_op   = op_t'(s_axis_tuser[1:0]);
  assign in_tsel = s_axis_tuser[2];
  assign in_cnt  = counts[in_tsel];
  assign in_full = (in_op == OP_INSERT) && (in_cnt >= CW'(DEPTH));

  assign s_axis_tready = (state == S_IDLE) && !pend_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;

  assign tail_sel = tails[tsel_r];
  assign done     = (state == S_RUN) && tail_sel.active;
  assign cur_cnt  = counts[tsel_r];

  for (genvar t = 0; t < 2; t++) begin : g_table
    token_t head_t;
    always_comb begin
      head_t        = head_tok;
      head_t.active = launch[t];
    end

    sht_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
    ) u_chain (
      .clk   (clk),
      .rst   (rst),
      .count (counts[t]),
      .head  (head_t),
      .tail  (tails[t])
    );
  end

  always_comb begin
    res.status = STAT_OK;
    res.id     = '0;
    cnt_next   = cur_cnt;
    unique case (op_r)
      OP_INSERT: begin
        if (full_r) begin
          res.status = STAT_FULL;
        end else begin
          cnt_next = cur_cnt + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (tail_sel.flag) begin
          cnt_next = cur_cnt - CW'(1);
        end else begin
          res.status = STAT_MISS;
        end
      end
      OP_LOOKUP: begin
        if (tail_sel.flag) begin
          res.id = tail_sel.carry[ID_W-1:0];
        end else begin
          res.status = STAT_MISS;
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_OUT_W'(cnt_next);
  end

  // request launch and table counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= '0;
      counts[0] <= '0;
      counts[1] <= '0;
    end else begin
      launch <= {accept && in_tsel, accept && !in_tsel};
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (done) begin
            counts[tsel_r] <= cnt_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      tsel_r   <= in_tsel;
      full_r   <= in_full;
      // entry layout: handle in the upper bits, id in the lower
      head_tok <= '{
        active:     1'b0,
        op:         in_full ? OP_NONE : in_op,
        flag:       1'b0,
        carry:      {s_axis_tdata[HANDLE_W-1:0], s_axis_tdata[ENTRY_W-1:HANDLE_W]},
        key_handle: s_axis_tdata[HANDLE_W-1:0],
        key_id:     s_axis_tdata[ENTRY_W-1:HANDLE_W]
      };
    end
  end

  // output register with one spare slot
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend_valid    <= 1'b0;
    end else if (done) begin
      if (m_axis_tvalid && !take) begin
        pend_res   <= res;
        pend_valid <= 1'b1;
      end else begin
        out_res       <= res;
        m_axis_tvalid <= 1'b1;
      end
    end else if (take) begin
      if (pend_valid) begin
        out_res    <= pend_res;
        pend_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_res.count, out_res.id};
  assign m_axis_tuser = out_res.status;

endmodule
